/* rtl/rrla_pkg.sv */
// Shared types and constants of the receive ring line assembler.
`default_nettype none

package rrla_pkg;

  localparam int LEN_W   = 6;
  localparam int LIMIT_W = 7;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_NOLINE  = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COPY,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         rx_byte;
    logic [LIMIT_W-1:0] line_limit;
  } rrla_in_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] line_length;
    logic             last;
  } rrla_out_t;

endpackage

`default_nettype wire

/* rtl/rrla_stream_if.sv */
// Valid/ready stream interface carrying one item of payload type T.
`default_nettype none

interface rrla_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/rrla_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module rrla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/rx_ring_line_assembler_core.sv */
// Receive ring buffer with line reader: stores bytes, returns newline-terminated lines.
//
//  channel | dir | payload                                        | accepted when
//  req     | in  | req_type, rx_byte, line_limit                  | valid && ready
//  res     | out | result_kind, out_byte, line_length, last       | valid && ready
//
// A received byte is written unless the ring is full. A line request passes accept,
// scan, copy and reply plus output stalls; with no newline pending it passes accept,
// scan and reply, and with a zero limit accept and reply. Both walks read one ring
// entry per cycle from the ring memory; copy holds a kept byte while res is full.
// req is ready only in idle; the result register lets res stall freely.
// Reset clears the ring indices, state and result valid; the ring contents are not cleared.
`default_nettype none

module rx_ring_line_assembler_core
  import rrla_pkg::*;
#(
  parameter int RING_DEPTH = 128,
  parameter int MAX_LINE   = 64
) (
  input logic          clk,
  input logic          rst,
  rrla_stream_if.sink   req,
  rrla_stream_if.source res
);

  localparam int IW   = $clog2(RING_DEPTH);
  localparam int CMPW = (IW > LEN_W) ? IW : LEN_W;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    logic [IW-1:0] r;
    if (i == IW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + IW'(1);
    end
    return r;
  endfunction

  state_t           state, state_next;
  logic [IW-1:0]    wi, ri, scan, pos, count;
  logic [LEN_W-1:0] written, cap;
  kind_t            reply_kind;
  logic             res_valid;
  rrla_out_t        res_data;

  logic             acc, slot_free, ram_we;
  logic [IW-1:0]    ram_raddr, wi_nx;
  logic [7:0]       rdata;
  logic [LIMIT_W-1:0] lim;
  logic             at_end, byte_ok, copy_adv, emit;
  rrla_out_t        emit_item;

  assign acc       = req.valid && req.ready;
  assign slot_free = !res_valid || res.ready;
  assign wi_nx     = ring_next(wi);
  assign lim       = (req.data.line_limit > LIMIT_W'(MAX_LINE)) ? LIMIT_W'(MAX_LINE)
                                                                : req.data.line_limit;
  assign at_end    = (pos == scan);
  assign byte_ok   = (rdata != CH_CR) && (written < cap);

  rrla_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi),
    .wdata (req.data.rx_byte),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && req.data.req_type) begin
          state_next = (lim == '0) ? ST_REPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan == wi) begin
          state_next = ST_REPLY;
        end else if (rdata == CH_LF) begin
          state_next = ST_COPY;
        end
      end
      ST_COPY: begin
        if (at_end) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = pos;
    copy_adv  = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        ram_raddr = ri;
        ram_we    = acc && !req.data.req_type && (wi_nx != ri);
      end
      ST_SCAN: begin
        if (rdata == CH_LF) begin
          ram_raddr = ri;
        end else begin
          ram_raddr = ring_next(scan);
        end
      end
      ST_COPY: begin
        copy_adv              = !at_end && (!byte_ok || slot_free);
        emit                  = !at_end && byte_ok && slot_free;
        emit_item.result_kind = KIND_BYTE;
        emit_item.out_byte    = rdata;
        ram_raddr             = copy_adv ? ring_next(pos) : pos;
      end
      ST_REPLY: begin
        emit                  = slot_free;
        emit_item.result_kind = reply_kind;
        emit_item.line_length = (reply_kind == KIND_DONE) ? written : '0;
        emit_item.last        = 1'b1;
      end
      default: begin
        ram_raddr = pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wi        <= '0;
      ri        <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        wi <= wi_nx;
      end
      if (state == ST_REPLY && slot_free) begin
        if (reply_kind == KIND_DISCARD) begin
          ri <= scan;
        end else if (reply_kind == KIND_DONE) begin
          ri <= ring_next(scan);
        end
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_data <= emit_item;
    end
    unique case (state)
      ST_IDLE: begin
        if (acc && req.data.req_type) begin
          scan       <= ri;
          pos        <= ri;
          count      <= '0;
          written    <= '0;
          cap        <= LEN_W'(lim - LIMIT_W'(1));
          reply_kind <= KIND_NOLINE;
        end
      end
      ST_SCAN: begin
        if (scan == wi) begin
          reply_kind <= (CMPW'(count) < CMPW'(cap)) ? KIND_NOLINE : KIND_DISCARD;
        end else if (rdata != CH_LF) begin
          scan  <= ring_next(scan);
          count <= count + IW'(1);
        end
      end
      ST_COPY: begin
        if (copy_adv) begin
          pos <= ring_next(pos);
        end
        if (emit) begin
          written <= written + LEN_W'(1);
        end
        if (at_end) begin
          reply_kind <= KIND_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule

`default_nettype wire
